>>> rtl/tsg_pkg.sv
// shared types and constants of the touch slide gesture detector
// no dependencies; used by tsg_cell and touch_slide_gesture_detector
package tsg_pkg;

  // history geometry
  localparam int unsigned HistDepth = 8;
  localparam int unsigned PosW      = $clog2(HistDepth);
  localparam int unsigned NumPads   = 4;
  localparam int unsigned PadIdxW   = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned GestW     = 2;
  localparam int unsigned GestTdataW = 8;

  // fill positions with a special meaning (position of the entry being written)
  localparam logic [PosW-1:0] PosLast       = PosW'(HistDepth - 1);
  localparam logic [PosW-1:0] PosNoRelease  = PosW'(6);
  localparam logic [PosW-1:0] PosSelectLo   = PosW'(1);
  localparam logic [PosW-1:0] PosSelectHi   = PosW'(2);

  // gesture codes
  localparam logic [GestW-1:0] GestSelect = 2'd0;
  localparam logic [GestW-1:0] GestRight  = 2'd1;
  localparam logic [GestW-1:0] GestLeft   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFirstPad  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondPad = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThirdPad  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFourthPad = 2'd3;

  // pad index reset values
  localparam logic [PadIdxW-1:0] FirstPadRst  = 4'd5;
  localparam logic [PadIdxW-1:0] SecondPadRst = 4'd4;
  localparam logic [PadIdxW-1:0] ThirdPadRst  = 4'd7;
  localparam logic [PadIdxW-1:0] FourthPadRst = 4'd8;

  // running match flags handed from cell to cell
  typedef struct packed {
    logic right;
    logic left;
  } match_t;

endpackage

>>> rtl/tsg_cell.sv
// one history entry of the gesture detector with its slide pattern compare
// depends on tsg_pkg; instantiated in a row by touch_slide_gesture_detector
module tsg_cell import tsg_pkg::*; #(
  parameter int unsigned STATUS_WIDTH = 10,
  parameter int unsigned INDEX        = 0
) (
  input  logic                                 clk_i,
  input  logic                                 wr_i,
  input  logic [STATUS_WIDTH-1:0]              data_i,
  input  logic [NumPads-1:0][STATUS_WIDTH-1:0] pads_i,
  input  match_t                               match_i,
  output match_t                               match_o
);

  logic [STATUS_WIDTH-1:0] hist_q;
  logic [STATUS_WIDTH-1:0] entry;
  logic [STATUS_WIDTH-1:0] right_pat;
  logic [STATUS_WIDTH-1:0] left_pat;

  localparam int unsigned K = INDEX / 2;

  // reference patterns for this position
  if (INDEX == HistDepth - 1) begin : g_tail
    assign right_pat = '0;
    assign left_pat  = '0;
  end else if (INDEX % 2 == 0) begin : g_single
    assign right_pat = pads_i[K];
    assign left_pat  = pads_i[NumPads-1-K];
  end else begin : g_pair
    assign right_pat = pads_i[K] | pads_i[K+1];
    assign left_pat  = pads_i[NumPads-1-K] | pads_i[NumPads-2-K];
  end

  // history entry, with the beat being written seen at once
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      hist_q <= data_i;
    end
  end

  assign entry = wr_i ? data_i : hist_q;

  // extend the match chain
  assign match_o.right = match_i.right && (entry == right_pat);
  assign match_o.left  = match_i.left  && (entry == left_pat);

endmodule

>>> rtl/touch_slide_gesture_detector.sv
// touch slide gesture detector: status history row, control and output register
// depends on tsg_pkg and tsg_cell
// a result is in the output register in the cycle after its status beat
// throughput: one status beat per cycle; a result waiting in the output register holds the input
// the select/slide decision is one pass along the row of eight history cells
// reset: pad indexes return to 5, 4, 7, 8, fill position and last status to zero;
// history entries are not reset
module touch_slide_gesture_detector import tsg_pkg::*; #(
  parameter int unsigned STATUS_WIDTH = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [PadIdxW-1:0]    cfg_data_i,
  // status input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [((STATUS_WIDTH+7)/8)*8-1:0] s_axis_tdata_i, // [STATUS_WIDTH-1:0] pad_status
  // gesture output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [GestTdataW-1:0] m_axis_tdata_o              // [1:0] gesture
);

  logic [NumPads-1:0][PadIdxW-1:0]      pad_idx_q;
  logic [NumPads-1:0][STATUS_WIDTH-1:0] pad_mask;
  logic [PosW-1:0]                      fill_q, fill_d;
  logic [STATUS_WIDTH-1:0]              last_q;
  logic [STATUS_WIDTH-1:0]              status;
  logic                                 out_valid_q, out_valid_d;
  logic [GestW-1:0]                     gest_q, gest_d;
  logic                                 accept, changed, release_hit, select_hit, gest_end;
  logic                                 res_valid;
  logic [GestW-1:0]                     res_code;
  match_t                               chain [HistDepth+1];

  assign status = s_axis_tdata_i[STATUS_WIDTH-1:0];

  // pad index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_idx_q[0] <= FirstPadRst;
      pad_idx_q[1] <= SecondPadRst;
      pad_idx_q[2] <= ThirdPadRst;
      pad_idx_q[3] <= FourthPadRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFirstPad:  pad_idx_q[0] <= cfg_data_i;
        CfgSecondPad: pad_idx_q[1] <= cfg_data_i;
        CfgThirdPad:  pad_idx_q[2] <= cfg_data_i;
        CfgFourthPad: pad_idx_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one-hot pad masks, zero when the index is past the status width
  always_comb begin
    for (int j = 0; j < NumPads; j++) begin
      pad_mask[j] = STATUS_WIDTH'(1) << pad_idx_q[j];
    end
  end

  // gesture control
  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign changed     = accept && (status != last_q);
  assign release_hit = changed && (status == '0) && (fill_q != PosNoRelease);
  assign select_hit  = release_hit && ((fill_q == PosSelectLo) || (fill_q == PosSelectHi));
  assign gest_end    = release_hit || (changed && (fill_q == PosLast));

  always_comb begin
    fill_d = fill_q;
    if (gest_end) begin
      fill_d = '0;
    end else if (changed) begin
      fill_d = fill_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      last_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (changed) begin
        last_q <= status;
      end
    end
  end

  // row of history cells carrying the match flags
  assign chain[0] = '{right: 1'b1, left: 1'b1};

  for (genvar i = 0; i < HistDepth; i++) begin : g_cell
    tsg_cell #(
      .STATUS_WIDTH (STATUS_WIDTH),
      .INDEX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .wr_i    (changed && (fill_q == PosW'(i))),
      .data_i  (status),
      .pads_i  (pad_mask),
      .match_i (chain[i]),
      .match_o (chain[i+1])
    );
  end

  // result selection, select wins over a slide match
  always_comb begin
    res_valid = 1'b0;
    res_code  = GestSelect;
    if (select_hit) begin
      res_valid = 1'b1;
      res_code  = GestSelect;
    end else if (gest_end && chain[HistDepth].right) begin
      res_valid = 1'b1;
      res_code  = GestRight;
    end else if (gest_end && chain[HistDepth].left) begin
      res_valid = 1'b1;
      res_code  = GestLeft;
    end
  end

  // output register
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    gest_d      = gest_q;
    if (s_axis_tready_o) begin
      out_valid_d = accept && res_valid;
      gest_d      = res_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gest_q <= gest_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(GestTdataW-GestW){1'b0}}, gest_q};

  // a select restarts the history
  a_select_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    select_hit |=> (fill_q == '0))
    else $error("fill position not cleared after select");

  // an unchanged status leaves the fill position alone
  a_unchanged_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status == last_q)) |=> $stable(fill_q))
    else $error("fill position moved without a status change");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> out_valid_q)
    else $error("input stalled with empty output register");

  // a reported gesture code is always a defined one
  a_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (gest_q == GestSelect || gest_q == GestRight || gest_q == GestLeft))
    else $error("undefined gesture code");

endmodule
